### rtl/core/eas_pkg.sv
// Shared types and constants for the eased servo trajectory core.
// Used by the channel interfaces, the shared arithmetic unit and the top level.
package eas_pkg;

  localparam int unsigned ECHO_W    = 16;
  localparam int unsigned ANGLE_W   = 8;
  localparam int unsigned DIVR_W    = 8;
  localparam int unsigned RANGE_W   = 10;
  localparam int unsigned SPD_W     = 4;
  localparam int unsigned STEP_W    = 12;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned T_W       = FRAC_W + 1;
  localparam int unsigned NUM_W     = 50;
  localparam int unsigned PROD_W    = 58;
  localparam int unsigned DIV_W     = 28;
  localparam int unsigned DSR_W     = 12;
  localparam int unsigned MLT_W     = 17;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 10;

  localparam logic [CNT_W-1:0] DIV_STEPS   = 5'd28;
  localparam logic [CNT_W-1:0] SQ_STEPS    = 5'd17;
  localparam logic [CNT_W-1:0] BYTE_STEPS  = 5'd8;

  localparam logic [DIVR_W-1:0]  ECHO_DIV_RST = 8'd58;
  localparam logic [RANGE_W-1:0] RANGE_RST    = 10'd400;
  localparam logic [SPD_W-1:0]   SPD_RST      = 4'd3;
  localparam logic [ANGLE_W-1:0] ANGLE_REST   = 8'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;

  localparam logic [T_W-1:0]   T_ONE   = 17'h10000;
  localparam logic [NUM_W-1:0] NUM_ONE = 50'h2_0000_0000_0000;

  localparam logic OPC_MEASURE = 1'b0;
  localparam logic OPC_TICK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DIV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD      = 2'd2;

  typedef enum logic {
    UOP_DIV = 1'b0,
    UOP_MUL = 1'b1
  } unit_op_e;

  typedef struct packed {
    unit_op_e          op;
    logic [PROD_W-1:0] a;
    logic [MLT_W-1:0]  b;
    logic [CNT_W-1:0]  cnt;
  } unit_cmd_t;

endpackage

### rtl/core/eas_if.sv
// Valid/ready channel interfaces for the eased servo trajectory core.
// Depends on eas_pkg for field widths.
interface eas_in_if import eas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ECHO_W-1:0] echo_us;

  modport source (output valid, output opcode, output echo_us, input ready);
  modport sink (input valid, input opcode, input echo_us, output ready);
endinterface

interface eas_out_if import eas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] servo_angle;
  logic               in_motion;
  logic               bad_measure;

  modport source (output valid, output servo_angle, output in_motion, output bad_measure,
                  input ready);
  modport sink (input valid, input servo_angle, input in_motion, input bad_measure,
                output ready);
endinterface

### rtl/core/eas_shared_unit.sv
// Shared bit-serial arithmetic unit: restoring divide and shift-add multiply
// over one adder, one bit per cycle. Depends on eas_pkg.
module eas_shared_unit import eas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  unit_cmd_t         cmd_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o,
  output logic [PROD_W-1:0] prod_o
);

  unit_op_e          op_q;
  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] acc_q, acc_d, opa_q, opa_d;
  logic [MLT_W-1:0]  opb_q, opb_d;
  logic [DSR_W:0]    rem_sh;
  logic [PROD_W-1:0] add_a, add_b, sum;
  logic              is_div, qbit;

  assign is_div = (op_q == UOP_DIV);
  assign rem_sh = {acc_q[DSR_W-1:0], opa_q[DIV_W-1]};

  always_comb begin
    add_a = PROD_W'(rem_sh);
    add_b = ~PROD_W'(opb_q[DSR_W-1:0]);
    case (op_q)
      UOP_DIV: begin
        add_a = PROD_W'(rem_sh);
        add_b = ~PROD_W'(opb_q[DSR_W-1:0]);
      end
      UOP_MUL: begin
        add_a = acc_q;
        add_b = opb_q[0] ? opa_q : '0;
      end
      default: begin
        add_a = acc_q;
        add_b = '0;
      end
    endcase
  end

  assign sum  = add_a + add_b + PROD_W'(is_div);
  assign qbit = ~sum[PROD_W-1];

  always_comb begin
    if (is_div) begin
      acc_d = qbit ? PROD_W'(sum[DSR_W:0]) : PROD_W'(rem_sh);
      opa_d = {opa_q[PROD_W-2:0], qbit};
      opb_d = opb_q;
    end else begin
      acc_d = sum;
      opa_d = {opa_q[PROD_W-2:0], 1'b0};
      opb_d = {1'b0, opb_q[MLT_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= UOP_DIV;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.cnt;
        op_q   <= cmd_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      opa_q <= cmd_i.a;
      opb_q <= cmd_i.b;
    end else if (busy_q) begin
      acc_q <= acc_d;
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = opa_q[DIV_W-1:0];
  assign prod_o = acc_q;

endmodule

### rtl/core/eased_servo_trajectory_core.sv
// Eased servo trajectory core: echo width to target angle, then an
// ease-in-out cubic move one step per tick word.
// Depends on eas_pkg, eas_if and eas_shared_unit.
//
// Usage:
//   in_i carries one word per operation: opcode 0 is an echo measurement
//   (echo_us), opcode 1 is one step tick. Every accepted word yields exactly
//   one word on out_o: servo_angle, in_motion and bad_measure.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write echo_divisor (0), full_range_cm (1)
//   and steps_per_degree (2) while no word is in flight.
//   One bit-serial adder does all dividing and every multiply but the step total, one bit a cycle;
//   the sequencer takes one word at a time and in_i.ready is low meanwhile.
//   Measurement: a 28-step divide, an 8-step multiply by 180, then a second
//   28-step divide, all before out_o.valid.
//   Tick during a move: a 28-step divide for t, two 17-step multiplies for
//   the cube and an 8-step scale.
//   Tick with no move: the unit is not used; the word goes straight to emit.
//   Reset: angle 90, no move, registers 58 / 400 / 3.
//   A stalled out_o holds its word; the core finishes the next word and
//   waits with it until the output register frees up.
module eased_servo_trajectory_core import eas_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  eas_in_if.sink               in_i,
  eas_out_if.source            out_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIST  = 9'b000000010,
    S_SCL   = 9'b000000100,
    S_ANG   = 9'b000001000,
    S_TDIV  = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_CUBE  = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [DIVR_W-1:0]  div_q, div_eff;
  logic [RANGE_W-1:0] range_q, range_eff;
  logic [SPD_W-1:0]   spd_q;

  logic [ANGLE_W-1:0] start_q, start_d, target_q, target_d, present_q, present_d;
  logic [STEP_W-1:0]  step_total_q, step_total_d, step_count_q, step_count_d, sc_inc;
  logic               active_q, active_d;

  logic               op_q, mv_q;
  logic [T_W-1:0]     t_q, t_c, base_q, base_c;
  logic               hi_q, hi_c;
  logic [T_W:0]       om_c;
  logic [NUM_W-1:0]   num_c;

  logic               u_start, u_done;
  unit_cmd_t          u_cmd;
  logic [DIV_W-1:0]   u_quot;
  logic [PROD_W-1:0]  u_prod;

  logic               in_acc, emit;
  logic               out_valid_q;
  logic [ANGLE_W-1:0] out_angle_q;
  logic               out_motion_q, out_bad_q;

  logic               ang_bad, up;
  logic [ANGLE_W-1:0] ang8, d_meas, diff, present_tick;
  logic [STEP_W-1:0]  st_calc;
  logic [ANGLE_W:0]   r9;

  assign in_acc    = in_i.valid && in_i.ready;
  assign div_eff   = (div_q == '0) ? DIVR_W'(1) : div_q;
  assign range_eff = (range_q == '0) ? RANGE_W'(1) : range_q;
  assign sc_inc    = step_count_q + STEP_W'(1);

  eas_shared_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (u_start),
    .cmd_i   (u_cmd),
    .done_o  (u_done),
    .quot_o  (u_quot),
    .prod_o  (u_prod)
  );

  always_comb begin
    t_c    = (u_quot > DIV_W'(T_ONE)) ? T_ONE : u_quot[T_W-1:0];
    hi_c   = t_c[T_W-1] | t_c[T_W-2];
    om_c   = {T_ONE, 1'b0} - {t_c, 1'b0};
    base_c = hi_c ? om_c[T_W-1:0] : t_c;
    num_c  = hi_q ? (NUM_ONE - u_prod[NUM_W-1:0]) : {u_prod[NUM_W-4:0], 3'b000};
  end

  always_comb begin
    up   = (target_q >= start_q);
    diff = up ? (target_q - start_q) : (start_q - target_q);
  end

  always_comb begin
    state_d = state_q;
    u_start = 1'b0;
    u_cmd   = '{op: UOP_DIV, a: '0, b: '0, cnt: '0};
    emit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OPC_MEASURE) begin
            u_start = 1'b1;
            u_cmd   = '{op: UOP_DIV, a: PROD_W'(in_i.echo_us), b: MLT_W'(div_eff),
                        cnt: DIV_STEPS};
            state_d = S_DIST;
          end else if (active_q) begin
            u_start = 1'b1;
            u_cmd   = '{op: UOP_DIV, a: PROD_W'({sc_inc, FRAC_W'(0)}),
                        b: MLT_W'(step_total_q), cnt: DIV_STEPS};
            state_d = S_TDIV;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_DIST: begin
        if (u_done) begin
          u_start = 1'b1;
          u_cmd   = '{op: UOP_MUL, a: PROD_W'(u_quot[ECHO_W-1:0]), b: MLT_W'(ANGLE_MAX),
                      cnt: BYTE_STEPS};
          state_d = S_SCL;
        end
      end
      S_SCL: begin
        if (u_done) begin
          u_start = 1'b1;
          u_cmd   = '{op: UOP_DIV, a: PROD_W'(u_prod[DIV_W-1:0]), b: MLT_W'(range_eff),
                      cnt: DIV_STEPS};
          state_d = S_ANG;
        end
      end
      S_ANG: begin
        if (u_done) begin
          state_d = S_EMIT;
        end
      end
      S_TDIV: begin
        if (u_done) begin
          u_start = 1'b1;
          u_cmd   = '{op: UOP_MUL, a: PROD_W'(base_c), b: base_c, cnt: SQ_STEPS};
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (u_done) begin
          u_start = 1'b1;
          u_cmd   = '{op: UOP_MUL, a: PROD_W'(u_prod[2*T_W-1:0]), b: base_q, cnt: SQ_STEPS};
          state_d = S_CUBE;
        end
      end
      S_CUBE: begin
        if (u_done) begin
          u_start = 1'b1;
          u_cmd   = '{op: UOP_MUL, a: PROD_W'(num_c), b: MLT_W'(diff), cnt: BYTE_STEPS};
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        if (u_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ang_bad      = (u_quot > DIV_W'(ANGLE_MAX));
    ang8         = u_quot[ANGLE_W-1:0];
    d_meas       = (ang8 >= present_q) ? (ang8 - present_q) : (present_q - ang8);
    st_calc      = STEP_W'(d_meas) * STEP_W'(spd_q);
    r9           = u_prod[PROD_W-1:PROD_W-ANGLE_W-1] + (ANGLE_W+1)'(u_prod[PROD_W-ANGLE_W-2]);
    present_tick = up ? (start_q + r9[ANGLE_W-1:0]) : (start_q - r9[ANGLE_W-1:0]);

    start_d      = start_q;
    target_d     = target_q;
    present_d    = present_q;
    step_total_d = step_total_q;
    step_count_d = step_count_q;
    active_d     = active_q;

    if (in_acc && in_i.opcode == OPC_TICK && active_q) begin
      step_count_d = sc_inc;
    end
    if (emit) begin
      if (op_q == OPC_MEASURE) begin
        if (!ang_bad) begin
          start_d      = present_q;
          target_d     = ang8;
          step_total_d = st_calc;
          step_count_d = '0;
          if (st_calc == '0) begin
            present_d = ang8;
            active_d  = 1'b0;
          end else begin
            active_d  = 1'b1;
          end
        end
      end else if (mv_q) begin
        present_d = present_tick;
        active_d  = (t_q != T_ONE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      div_q        <= ECHO_DIV_RST;
      range_q      <= RANGE_RST;
      spd_q        <= SPD_RST;
      start_q      <= '0;
      target_q     <= '0;
      present_q    <= ANGLE_REST;
      step_total_q <= '0;
      step_count_q <= '0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_q      <= start_d;
      target_q     <= target_d;
      present_q    <= present_d;
      step_total_q <= step_total_d;
      step_count_q <= step_count_d;
      active_q     <= active_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ECHO_DIV: div_q   <= cfg_wdata_i[DIVR_W-1:0];
          CFG_RANGE:    range_q <= cfg_wdata_i[RANGE_W-1:0];
          CFG_SPD:      spd_q   <= cfg_wdata_i[SPD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_i.opcode;
      mv_q <= active_q;
    end
    if (state_q == S_TDIV && u_done) begin
      t_q    <= t_c;
      hi_q   <= hi_c;
      base_q <= base_c;
    end
    if (emit) begin
      out_angle_q  <= present_d;
      out_motion_q <= active_d;
      out_bad_q    <= (op_q == OPC_MEASURE) && ang_bad;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.servo_angle = out_angle_q;
  assign out_o.in_motion   = out_motion_q;
  assign out_o.bad_measure = out_bad_q;

`ifndef SYNTHESIS
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    present_q <= ANGLE_MAX)
    else $error("servo angle beyond full scale");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> step_count_q <= step_total_q)
    else $error("step count passed step total during a move");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> !(state_q == S_IDLE || state_q == S_EMIT))
    else $error("unit finished with no sequencer state waiting");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output word raised outside emit");
`endif

endmodule
